// ----- src/trsw_pkg.sv -----
// Shared types, constants and helpers for the transmit/receive switch sequencer.
package trsw_pkg;

  localparam int DELAY_BITS = 8;
  localparam int STEP_BITS = 8;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS = 8;
  localparam int WIDE_BITS = 16;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE_SELECT = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_DELAY = 1'd1;

  localparam int LV_S1 = 0;
  localparam int LV_S2 = 1;
  localparam int LV_S3 = 2;
  localparam int LV_PLUS = 3;

  localparam logic [WIDE_BITS-1:0] DELAY_CAP = WIDE_BITS'((1 << DELAY_BITS) - 1);

  typedef enum logic [13:0] {
    PH_IDLE    = 14'b00000000000001,
    PH_B_ON1   = 14'b00000000000010,
    PH_B_ON2   = 14'b00000000000100,
    PH_B_ON3   = 14'b00000000001000,
    PH_B_HOLD  = 14'b00000000010000,
    PH_B_OFF2  = 14'b00000000100000,
    PH_B_OFF1  = 14'b00000001000000,
    PH_L_ON1   = 14'b00000010000000,
    PH_L_ON2   = 14'b00000100000000,
    PH_L_ON3   = 14'b00001000000000,
    PH_L_HOLD  = 14'b00010000000000,
    PH_L_OFF2  = 14'b00100000000000,
    PH_L_OFF1  = 14'b01000000000000,
    PH_L_OFFP  = 14'b10000000000000
  } phase_t;

  typedef struct packed {
    logic                 mode_select;
    logic [STEP_BITS-1:0] step_delay;
  } cfg_t;

  typedef struct packed {
    logic stage_one;
    logic stage_two;
    logic stage_three;
    logic plus_line;
    logic sequencing;
  } result_t;

  function automatic logic [DELAY_BITS-1:0] load_value(input logic [STEP_BITS-1:0] step);
    logic [WIDE_BITS-1:0] d;
    d = WIDE_BITS'(step);
    if (d == '0) begin
      d = WIDE_BITS'(1);
    end
    if (d > DELAY_CAP) begin
      d = DELAY_CAP;
    end
    return d[DELAY_BITS-1:0];
  endfunction

endpackage

// ----- src/trsw_cfg.sv -----
// Configuration registers for mode and step delay.
module trsw_cfg import trsw_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                      cfg
);

  logic                 mode_select;
  logic [STEP_BITS-1:0] step_delay;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_select <= 1'b1;
      step_delay <= STEP_BITS'(15);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE_SELECT: mode_select <= cfg_data[0];
        CFG_STEP_DELAY:  step_delay <= cfg_data[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.mode_select = mode_select;
  assign cfg.step_delay = step_delay;

endmodule

// ----- src/trsw_core.sv -----
// Sequencer state registers and the per-tick next-state logic.
module trsw_core import trsw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  logic    ptt_active,
  input  cfg_t    cfg,
  output result_t result
);

  phase_t                phase;
  phase_t                phase_next;
  logic [DELAY_BITS-1:0] wait_count;
  logic [DELAY_BITS-1:0] wait_count_next;
  logic [3:0]            levels;
  logic [3:0]            levels_next;
  logic                  counting;
  logic                  expired;
  logic [DELAY_BITS-1:0] load;

  assign load = load_value(cfg.step_delay);
  assign counting = (phase != PH_IDLE) && (phase != PH_B_HOLD) && (phase != PH_L_HOLD);

  always_comb begin
    phase_next = phase;
    wait_count_next = wait_count;
    levels_next = levels;
    expired = 1'b0;
    if (counting) begin
      if (wait_count <= DELAY_BITS'(1)) begin
        expired = 1'b1;
      end else begin
        wait_count_next = wait_count - DELAY_BITS'(1);
      end
    end
    case (phase)
      PH_IDLE: begin
        if (ptt_active) begin
          wait_count_next = load;
          if (cfg.mode_select) begin
            phase_next = PH_B_ON1;
          end else begin
            levels_next[LV_PLUS] = 1'b0;
            phase_next = PH_L_ON1;
          end
        end
      end
      PH_B_ON1, PH_L_ON1: begin
        if (expired) begin
          levels_next[LV_S1] = 1'b1;
          phase_next = (phase == PH_B_ON1) ? PH_B_ON2 : PH_L_ON2;
          wait_count_next = load;
        end
      end
      PH_B_ON2, PH_L_ON2: begin
        if (expired) begin
          levels_next[LV_S2] = 1'b1;
          phase_next = (phase == PH_B_ON2) ? PH_B_ON3 : PH_L_ON3;
          wait_count_next = load;
        end
      end
      PH_B_ON3: begin
        if (expired) begin
          levels_next[LV_S3] = 1'b1;
          levels_next[LV_PLUS] = 1'b1;
          phase_next = PH_B_HOLD;
          wait_count_next = '0;
        end
      end
      PH_L_ON3: begin
        if (expired) begin
          levels_next[LV_S3] = 1'b1;
          phase_next = PH_L_HOLD;
          wait_count_next = '0;
        end
      end
      PH_B_HOLD: begin
        if (!ptt_active) begin
          levels_next[LV_S3] = 1'b0;
          levels_next[LV_PLUS] = 1'b0;
          phase_next = PH_B_OFF2;
          wait_count_next = load;
        end
      end
      PH_L_HOLD: begin
        if (!ptt_active) begin
          levels_next[LV_S3] = 1'b0;
          phase_next = PH_L_OFF2;
          wait_count_next = load;
        end
      end
      PH_B_OFF2, PH_L_OFF2: begin
        if (expired) begin
          levels_next[LV_S2] = 1'b0;
          phase_next = (phase == PH_B_OFF2) ? PH_B_OFF1 : PH_L_OFF1;
          wait_count_next = load;
        end
      end
      PH_B_OFF1: begin
        if (expired) begin
          levels_next[LV_S1] = 1'b0;
          phase_next = PH_IDLE;
          wait_count_next = '0;
        end
      end
      PH_L_OFF1: begin
        if (expired) begin
          levels_next[LV_S1] = 1'b0;
          phase_next = PH_L_OFFP;
          wait_count_next = load;
        end
      end
      PH_L_OFFP: begin
        if (expired) begin
          levels_next[LV_PLUS] = 1'b1;
          phase_next = PH_IDLE;
          wait_count_next = '0;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        wait_count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      wait_count <= '0;
      levels <= '0;
    end else if (accept) begin
      phase <= phase_next;
      wait_count <= wait_count_next;
      levels <= levels_next;
    end
  end

  assign result.stage_one = levels_next[LV_S1];
  assign result.stage_two = levels_next[LV_S2];
  assign result.stage_three = levels_next[LV_S3];
  assign result.plus_line = levels_next[LV_PLUS];
  assign result.sequencing = (phase_next != PH_IDLE) && (phase_next != PH_B_HOLD) &&
                             (phase_next != PH_L_HOLD);

endmodule

// ----- src/tx_rx_switch_sequencer_core.sv -----
// Top level of the push-to-talk transmit/receive switch sequencer.
//
//   channel | signals                         | direction
//   --------+---------------------------------+----------
//   in      | in_valid, in_stall, ptt_active  | tick in
//   out     | out_valid, out_stall, stage_*,  | levels out
//           | plus_line, sequencing           |
//   cfg     | cfg_valid, cfg_ready, cfg_index,| register write
//           | cfg_data                        |
//
// The state update happens at the input transfer and the result lands in the output
// register on the same edge, so one tick per cycle is sustained while the output is not stalled.
// A tick is taken whenever the output register is empty or is being drained.
// Reset clears the phase, counter and levels and loads mode 1 and step delay 15.
// A stall on the output holds the result and stalls the input only while it is full.
module tx_rx_switch_sequencer_core import trsw_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      ptt_active,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      stage_one,
  output logic                      stage_two,
  output logic                      stage_three,
  output logic                      plus_line,
  output logic                      sequencing,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cfg_t    cfg;
  result_t result;
  result_t out_reg;
  logic    accept;

  trsw_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  trsw_core u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .ptt_active (ptt_active),
    .cfg        (cfg),
    .result     (result)
  );

  assign in_stall = out_valid && out_stall;
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_reg <= result;
    end
  end

  assign stage_one = out_reg.stage_one;
  assign stage_two = out_reg.stage_two;
  assign stage_three = out_reg.stage_three;
  assign plus_line = out_reg.plus_line;
  assign sequencing = out_reg.sequencing;

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted tick did not reach the output register");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output register");

  a_stage_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((!stage_three || stage_two) && (!stage_two || stage_one)))
    else $error("stage levels out of order");

  a_settled_levels: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !sequencing) |-> ((stage_one == stage_two) && (stage_two == stage_three)))
    else $error("stages not all equal outside a sequence");

endmodule

// ----- verif/tx_rx_switch_sequencer_checker.sv -----
// Checker that predicts the sequencer's levels for every tick and compares each output transfer.
module tx_rx_switch_sequencer_checker import trsw_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      ptt_active,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      stage_one,
  input  logic                      stage_two,
  input  logic                      stage_three,
  input  logic                      plus_line,
  input  logic                      sequencing,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output int                        error_count,
  output int                        pending,
  output int                        checked,
  output int                        bias_runs,
  output int                        lna_runs
);

  localparam logic [STEP_BITS-1:0] RESET_STEP = 8'd15;
  localparam int COUNT_MAX = (1 << DELAY_BITS) - 1;

  logic                  mode_sel = 1'b1;
  logic [STEP_BITS-1:0]  step_setting = RESET_STEP;
  phase_t                phase = PH_IDLE;
  logic [DELAY_BITS-1:0] ticks_left = '0;
  logic [3:0]            levels = '0;
  result_t               levels_due[$];
  int                    errors_n = 0;
  int                    checked_n = 0;
  int                    bias_n = 0;
  int                    lna_n = 0;
  string                 field_name[5] = '{"stage_one", "stage_two", "stage_three",
                                           "plus_line", "sequencing"};

  function automatic logic [DELAY_BITS-1:0] step_count();
    int d;
    d = int'(step_setting);
    if (d == 0) begin
      d = 1;
    end
    if (d > COUNT_MAX) begin
      d = COUNT_MAX;
    end
    return DELAY_BITS'(d);
  endfunction

  function automatic logic in_motion(input phase_t p);
    return p != PH_IDLE && p != PH_B_HOLD && p != PH_L_HOLD;
  endfunction

  task automatic sequence_tick(input logic keyed, output result_t r);
    logic expired;
    expired = 1'b0;
    if (in_motion(phase)) begin
      if (ticks_left <= 1) begin
        expired = 1'b1;
      end else begin
        ticks_left = ticks_left - 1'b1;
      end
    end
    case (phase)
      PH_IDLE: begin
        if (keyed) begin
          if (mode_sel) begin
            phase = PH_B_ON1;
            bias_n++;
          end else begin
            levels[LV_PLUS] = 1'b0;
            phase = PH_L_ON1;
            lna_n++;
          end
          ticks_left = step_count();
        end
      end
      PH_B_ON1, PH_L_ON1: begin
        if (expired) begin
          levels[LV_S1] = 1'b1;
          phase = (phase == PH_B_ON1) ? PH_B_ON2 : PH_L_ON2;
          ticks_left = step_count();
        end
      end
      PH_B_ON2, PH_L_ON2: begin
        if (expired) begin
          levels[LV_S2] = 1'b1;
          phase = (phase == PH_B_ON2) ? PH_B_ON3 : PH_L_ON3;
          ticks_left = step_count();
        end
      end
      PH_B_ON3: begin
        if (expired) begin
          levels[LV_S3] = 1'b1;
          levels[LV_PLUS] = 1'b1;
          phase = PH_B_HOLD;
          ticks_left = '0;
        end
      end
      PH_L_ON3: begin
        if (expired) begin
          levels[LV_S3] = 1'b1;
          phase = PH_L_HOLD;
          ticks_left = '0;
        end
      end
      PH_B_HOLD: begin
        if (!keyed) begin
          levels[LV_S3] = 1'b0;
          levels[LV_PLUS] = 1'b0;
          phase = PH_B_OFF2;
          ticks_left = step_count();
        end
      end
      PH_L_HOLD: begin
        if (!keyed) begin
          levels[LV_S3] = 1'b0;
          phase = PH_L_OFF2;
          ticks_left = step_count();
        end
      end
      PH_B_OFF2, PH_L_OFF2: begin
        if (expired) begin
          levels[LV_S2] = 1'b0;
          phase = (phase == PH_B_OFF2) ? PH_B_OFF1 : PH_L_OFF1;
          ticks_left = step_count();
        end
      end
      PH_B_OFF1: begin
        if (expired) begin
          levels[LV_S1] = 1'b0;
          phase = PH_IDLE;
          ticks_left = '0;
        end
      end
      PH_L_OFF1: begin
        if (expired) begin
          levels[LV_S1] = 1'b0;
          phase = PH_L_OFFP;
          ticks_left = step_count();
        end
      end
      PH_L_OFFP: begin
        if (expired) begin
          levels[LV_PLUS] = 1'b1;
          phase = PH_IDLE;
          ticks_left = '0;
        end
      end
      default: begin
        phase = PH_IDLE;
        ticks_left = '0;
      end
    endcase
    r.stage_one = levels[LV_S1];
    r.stage_two = levels[LV_S2];
    r.stage_three = levels[LV_S3];
    r.plus_line = levels[LV_PLUS];
    r.sequencing = in_motion(phase);
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    string   bad;
    if (rst) begin
      mode_sel = 1'b1;
      step_setting = RESET_STEP;
      phase = PH_IDLE;
      ticks_left = '0;
      levels = '0;
      levels_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = result_t'({stage_one, stage_two, stage_three, plus_line, sequencing});
        if (levels_due.size() == 0) begin
          errors_n++;
          $display("%0t: unexpected transfer: expected none, actual %b", $time, got);
        end else begin
          want = levels_due.pop_front();
          checked_n++;
          bad = "";
          for (int k = 0; k < 5; k++) begin
            if (want[4-k] !== got[4-k]) begin
              bad = {bad, " ", field_name[k]};
            end
          end
          if (bad != "") begin
            errors_n++;
            $display("%0t: mismatch in%s: expected %b, actual %b", $time, bad, want, got);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE_SELECT: mode_sel = cfg_data[0];
          CFG_STEP_DELAY:  step_setting = cfg_data[STEP_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        sequence_tick(ptt_active, want);
        levels_due.push_back(want);
      end
    end
    error_count <= errors_n;
    pending <= levels_due.size();
    checked <= checked_n;
    bias_runs <= bias_n;
    lna_runs <= lna_n;
  end

endmodule

// ----- verif/testbench.sv -----
// Top of the sequencer testbench: clock, reset, tick and register stimulus, and the verdict.
module testbench;
  import trsw_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD = 300;
  localparam logic [STEP_BITS-1:0] LONG_STEP = 8'd16;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic                      ptt_active;
  logic                      out_valid;
  logic                      out_stall;
  logic                      stage_one;
  logic                      stage_two;
  logic                      stage_three;
  logic                      plus_line;
  logic                      sequencing;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  int error_count;
  int pending;
  int checked;
  int bias_runs;
  int lna_runs;

  int tx_gap_pct = 0;
  int rx_busy_pct = 0;
  bit rx_hold_req = 1'b0;
  int ticks_sent = 0;
  int cfg_writes = 0;
  int cycle_count = 0;

  tx_rx_switch_sequencer_core i_dut (.*);

  tx_rx_switch_sequencer_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The receiver: random stall bursts, or one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(1, 100) <= rx_busy_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_tick(input logic keyed);
    int gap;
    if ($urandom_range(1, 100) <= tx_gap_pct) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    ptt_active <= keyed;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic mode, input logic [STEP_BITS-1:0] step);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MODE_SELECT;
    cfg_data <= CFG_DATA_BITS'(mode);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_STEP_DELAY;
    cfg_data <= CFG_DATA_BITS'(step);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes += 2;
  endtask

  task automatic run_phase(input int quota, input bit idling, input bit hold_off);
    logic                 mode;
    logic [STEP_BITS-1:0] step;
    int                   pick;
    int                   span;
    int                   len;
    int                   sent;
    mode = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      step = '0;
    end else if (pick < 8) begin
      step = STEP_BITS'($urandom_range(1, 4));
    end else begin
      step = STEP_BITS'($urandom_range(5, 12));
    end
    wait_results();
    set_config(mode, step);
    if (idling) begin
      tx_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
      rx_busy_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
    end else begin
      tx_gap_pct = 0;
      rx_busy_pct = 0;
    end
    if (hold_off) begin
      rx_hold_req = 1'b1;
    end
    span = 3 * ((step == 0) ? 1 : int'(step)) + 4;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 9) < 7) begin
        // A key-down and release, long enough at times to reach the hold phase.
        len = $urandom_range(1, span);
        repeat (len) send_tick(1'b1);
        sent += len;
        len = $urandom_range(1, span);
        repeat (len) send_tick(1'b0);
        sent += len;
      end else begin
        len = $urandom_range(1, 8);
        repeat (len) send_tick(1'($urandom_range(0, 1)));
        sent += len;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    ptt_active = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MODE_SELECT;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    tx_gap_pct = 10;
    rx_busy_pct = 10;
    repeat (2) send_tick(1'b0);
    wait_results();
    set_config(1'b1, 8'd1);
    repeat (4) send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    wait_results();
    set_config(1'b0, 8'd1);
    repeat (4) send_tick(1'b1);
    repeat (4) send_tick(1'b0);
    // A zero delay acts as one; a short key still runs the whole on-sequence.
    wait_results();
    set_config(1'b1, 8'd0);
    repeat (2) send_tick(1'b0);
    send_tick(1'b1);
    repeat (5) send_tick(1'b0);

    wait_results();
    set_config(1'b0, LONG_STEP);
    repeat (3 * int'(LONG_STEP) + 4) send_tick(1'b1);
    repeat (3 * int'(LONG_STEP) + 4) send_tick(1'b0);
    wait_results();
    set_config(1'b1, LONG_STEP);
    repeat (3 * int'(LONG_STEP) + 4) send_tick(1'b1);
    repeat (2 * int'(LONG_STEP) + 4) send_tick(1'b0);

    for (int p = 0; p < 8; p++) begin
      run_phase(25, 1'b1, p == 3);
    end
    run_phase(25, 1'b0, 1'b0);

    wait_results();
    repeat (4) @(posedge clk);
    $display("Sent %0d ticks and %0d register writes in both modes, step delays 0 to %0d.",
             ticks_sent, cfg_writes, LONG_STEP);
    $display("Checked %0d results over %0d bias and %0d LNA sequences.",
             checked, bias_runs, lna_runs);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
